@@ hdl/sslt_pkg.sv @@
// sslt_pkg: shared types, register codes and constants for the sensor status led tracker
// used by sslt_cfg_regs, sslt_engine and sensor_status_led_tracker_core
// no dependencies

package sslt_pkg;

    // table size default and moisture channel count
    localparam int SLOTS_DEF     = 3;
    localparam int ADC_CHANNELS  = 4;
    localparam int MOIST_CHECKED = (ADC_CHANNELS - 1 < 3) ? (ADC_CHANNELS - 1) : 3;

    // field widths
    localparam int ADDR_W    = 48;
    localparam int INTV_W    = 16;
    localparam int BATT_W    = 16;
    localparam int MOIST_W   = 10;
    localparam int EXTRA_W   = 8;
    localparam int PERIOD_W  = 16;
    localparam int TIME_W    = 32;
    localparam int LED_OUT_W = 9;
    localparam int IDX_OUT_W = 2;
    localparam int LIMIT_W   = 27;

    // stream payload widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;

    // apb
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [MOIST_W-1:0] OPEN_CIRCUIT = 10'd1023;
    localparam logic [9:0]         MS_PER_SEC   = 10'd1000;

    // led colors within one slot
    localparam logic [2:0] LED_BLUE  = 3'b001;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_RED   = 3'b100;

    // register reset values
    localparam logic [BATT_W-1:0]   BATT_THR_RST   = 16'd0;
    localparam logic [MOIST_W-1:0]  WATER_THR_RST  = 10'd1023;
    localparam logic [EXTRA_W-1:0]  EXTRA_SEC_RST  = 8'd0;
    localparam logic [PERIOD_W-1:0] SWEEP_PER_RST  = 16'd500;

    typedef enum logic [1:0] {
        REG_BATTERY_THR  = 2'd0,
        REG_WATER_THR    = 2'd1,
        REG_EXTRA_SEC    = 2'd2,
        REG_SWEEP_PERIOD = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [BATT_W-1:0]   battery_threshold;
        logic [MOIST_W-1:0]  water_threshold;
        logic [EXTRA_W-1:0]  extra_seconds;
        logic [PERIOD_W-1:0] sweep_period_ms;
    } t_cfg;

    typedef struct packed {
        logic                action;
        logic [ADDR_W-1:0]   node_address;
        logic [INTV_W-1:0]   interval_seconds;
        logic [BATT_W-1:0]   battery_level;
        logic [MOIST_W-1:0]  moisture_a;
        logic [MOIST_W-1:0]  moisture_b;
        logic [MOIST_W-1:0]  moisture_c;
    } t_item;

    typedef struct packed {
        logic [LED_OUT_W-1:0] led_bits;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 slot_found;
    } t_result;

endpackage

@@ hdl/sslt_cfg_regs.sv @@
// sslt_cfg_regs: apb register file for thresholds, grace time and sweep period
// depends on sslt_pkg

module sslt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sslt_pkg::APB_AW-1:0]    paddr,
    input  logic [sslt_pkg::APB_DW-1:0]    pwdata,
    output logic [sslt_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output sslt_pkg::t_cfg                 o_cfg
);

    sslt_pkg::t_cfg   r_cfg;
    sslt_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = sslt_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.battery_threshold <= sslt_pkg::BATT_THR_RST;
            r_cfg.water_threshold   <= sslt_pkg::WATER_THR_RST;
            r_cfg.extra_seconds     <= sslt_pkg::EXTRA_SEC_RST;
            r_cfg.sweep_period_ms   <= sslt_pkg::SWEEP_PER_RST;
        end else if (wr_en) begin
            case (reg_idx)
                sslt_pkg::REG_BATTERY_THR:  r_cfg.battery_threshold <= pwdata[15:0];
                sslt_pkg::REG_WATER_THR:    r_cfg.water_threshold   <= pwdata[9:0];
                sslt_pkg::REG_EXTRA_SEC:    r_cfg.extra_seconds     <= pwdata[7:0];
                sslt_pkg::REG_SWEEP_PERIOD: r_cfg.sweep_period_ms   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sslt_pkg::REG_BATTERY_THR:  prdata = {16'd0, r_cfg.battery_threshold};
            sslt_pkg::REG_WATER_THR:    prdata = {22'd0, r_cfg.water_threshold};
            sslt_pkg::REG_EXTRA_SEC:    prdata = {24'd0, r_cfg.extra_seconds};
            sslt_pkg::REG_SWEEP_PERIOD: prdata = {16'd0, r_cfg.sweep_period_ms};
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/sslt_engine.sv @@
// sslt_engine: slot table, led register, millisecond clock and timeout sweep
// one item is applied per cycle when i_valid is high; depends on sslt_pkg

module sslt_engine #(
    parameter int SLOTS = sslt_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sslt_pkg::t_item   i_item,
    input  sslt_pkg::t_cfg    i_cfg,
    output sslt_pkg::t_result o_res
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LED_W  = 3 * SLOTS;

    logic [sslt_pkg::ADDR_W-1:0] r_addr     [SLOTS];
    logic [SLOTS-1:0]            r_used, n_used;
    logic [sslt_pkg::INTV_W-1:0] r_interval [SLOTS];
    logic [sslt_pkg::INTV_W-1:0] n_interval [SLOTS];
    logic [sslt_pkg::TIME_W-1:0] r_last     [SLOTS];
    logic [sslt_pkg::TIME_W-1:0] n_last     [SLOTS];
    logic [LED_W-1:0]            r_led, n_led;
    logic [sslt_pkg::TIME_W-1:0] r_time, n_time;
    logic [sslt_pkg::PERIOD_W-1:0] r_cnt, n_cnt;

    logic                        match_any, free_any, found;
    logic [SLOT_W-1:0]           match_idx, free_idx, sel_idx;
    logic [sslt_pkg::TIME_W-1:0] time_inc;
    logic [sslt_pkg::PERIOD_W:0] cnt_inc, period;
    logic [SLOTS-1:0]            tmo;
    logic [2:0]                  color;
    logic                        wet;
    logic [LED_W+sslt_pkg::LED_OUT_W-1:0] led_pad;
    logic [SLOT_W+sslt_pkg::IDX_OUT_W-1:0] idx_pad;

    // address lookup, lowest slot wins
    always_comb begin
        match_any = 1'b0;
        free_any  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_used[s] && r_addr[s] == i_item.node_address) begin
                match_any = 1'b1;
                match_idx = SLOT_W'(s);
            end
            if (!r_used[s]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign found   = ~i_item.action & (match_any | free_any);
    assign sel_idx = match_any ? match_idx : free_idx;

    // moisture check over the wired channels
    always_comb begin
        logic [sslt_pkg::MOIST_W-1:0] m [3];
        m[0] = i_item.moisture_a;
        m[1] = i_item.moisture_b;
        m[2] = i_item.moisture_c;
        wet  = 1'b0;
        for (int c = 0; c < sslt_pkg::MOIST_CHECKED; c++) begin
            if (m[c] < sslt_pkg::OPEN_CIRCUIT && m[c] > i_cfg.water_threshold) begin
                wet = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_item.battery_level < i_cfg.battery_threshold) begin
            color = sslt_pkg::LED_RED;
        end else if (wet) begin
            color = sslt_pkg::LED_BLUE;
        end else begin
            color = sslt_pkg::LED_GREEN;
        end
    end

    // timeout test per slot against the advanced clock
    assign time_inc = r_time + 32'd1;

    always_comb begin
        logic [sslt_pkg::INTV_W:0]   secs;
        logic [sslt_pkg::LIMIT_W-1:0] limit;
        logic [sslt_pkg::TIME_W-1:0] diff;
        for (int s = 0; s < SLOTS; s++) begin
            secs   = {1'b0, r_interval[s]} + 17'(i_cfg.extra_seconds);
            limit  = sslt_pkg::LIMIT_W'(secs) * sslt_pkg::LIMIT_W'(sslt_pkg::MS_PER_SEC);
            diff   = time_inc - r_last[s];
            tmo[s] = ~diff[sslt_pkg::TIME_W-1] &&
                     (diff > sslt_pkg::TIME_W'(limit));
        end
    end

    // a zero period sweeps on every tick
    assign cnt_inc = {1'b0, r_cnt} + 17'd1;
    assign period  = (i_cfg.sweep_period_ms == '0) ? 17'd1 : {1'b0, i_cfg.sweep_period_ms};

    always_comb begin
        n_used     = r_used;
        n_interval = r_interval;
        n_last     = r_last;
        n_led      = r_led;
        n_time     = r_time;
        n_cnt      = r_cnt;
        if (i_item.action) begin
            n_time = time_inc;
            if (cnt_inc >= period) begin
                n_cnt = '0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (tmo[s]) begin
                        n_led[3*s +: 3] = 3'b000;
                    end
                end
            end else begin
                n_cnt = cnt_inc[sslt_pkg::PERIOD_W-1:0];
            end
        end else if (found) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (SLOT_W'(s) == sel_idx) begin
                    n_used[s]       = 1'b1;
                    n_interval[s]   = i_item.interval_seconds;
                    n_last[s]       = r_time;
                    n_led[3*s +: 3] = color;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_led  <= '0;
            r_time <= '0;
            r_cnt  <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_interval[s] <= '0;
                r_last[s]     <= '0;
            end
        end else if (i_valid) begin
            r_used     <= n_used;
            r_interval <= n_interval;
            r_last     <= n_last;
            r_led      <= n_led;
            r_time     <= n_time;
            r_cnt      <= n_cnt;
        end
    end

    // addresses are only read behind a used bit
    always_ff @(posedge i_clk) begin
        if (i_valid && !i_item.action && !match_any && free_any) begin
            r_addr[free_idx] <= i_item.node_address;
        end
    end

    assign led_pad = {{sslt_pkg::LED_OUT_W{1'b0}}, n_led};
    assign idx_pad = {{sslt_pkg::IDX_OUT_W{1'b0}}, (found ? sel_idx : {SLOT_W{1'b0}})};

    assign o_res.led_bits   = led_pad[sslt_pkg::LED_OUT_W-1:0];
    assign o_res.slot_index = idx_pad[sslt_pkg::IDX_OUT_W-1:0];
    assign o_res.slot_found = found;

    a_tick_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.action |-> !o_res.slot_found && o_res.slot_index == '0)
        else $error("tick reported a slot");

    a_used_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> $countones(r_used) >= $past($countones(r_used)))
        else $error("slot used bit dropped");

    a_hit_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && found |=> r_used != '0)
        else $error("report with slot left table empty");

endmodule

@@ hdl/sensor_status_led_tracker_core.sv @@
// sensor_status_led_tracker_core: top level with stream input/output registers
// depends on sslt_pkg, sslt_cfg_regs and sslt_engine
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------
//   s       | in        | i_s_tvalid / o_s_tready  | i_s_tdata (112b), i_s_tuser (action)
//   m       | out       | o_m_tvalid / i_m_tready  | o_m_tdata (16b), o_m_tuser (slot_found)
//   apb     | in        | psel, penable, pready    | paddr, pwdata, pwrite, prdata
//
// one item per cycle sustained while results are taken; an accepted item passes through
// the input register and then the result register around the slot engine
// i_rst_n is synchronous, active low; clears the slot table, led register, clock,
// sweep counter, configuration and both valid flags (no clearing pass)
// a stalled result holds the output register; the input register still takes one
// more item, then o_s_tready drops until the result is taken

module sensor_status_led_tracker_core #(
    parameter int SLOTS = sslt_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // stream in
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [47:0] node_address, [63:48] interval_seconds, [79:64] battery_level,
    // [89:80] moisture_a, [99:90] moisture_b, [109:100] moisture_c, [111:110] zero
    input  logic [sslt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] action (0 report, 1 tick)
    input  logic                             i_s_tuser,
    // stream out
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [8:0] led_bits, [10:9] slot_index, [15:11] zero
    output logic [sslt_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // [0] slot_found
    output logic                             o_m_tuser,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sslt_pkg::APB_AW-1:0]      paddr,
    input  logic [sslt_pkg::APB_DW-1:0]      pwdata,
    output logic [sslt_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    sslt_pkg::t_cfg    cfg;
    sslt_pkg::t_item   r_in, n_in;
    logic              r_in_vld;
    sslt_pkg::t_result r_out, eng_res;
    logic              r_out_vld;
    logic              s_xfer;
    logic              advance;

    sslt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // item in the input register moves on when the result register is free or draining
    assign advance    = r_in_vld & (~r_out_vld | i_m_tready);
    assign o_s_tready = ~r_in_vld | advance;
    assign s_xfer     = i_s_tvalid & o_s_tready;

    // unpack the incoming transaction
    always_comb begin
        n_in.action           = i_s_tuser;
        n_in.node_address     = i_s_tdata[47:0];
        n_in.interval_seconds = i_s_tdata[63:48];
        n_in.battery_level    = i_s_tdata[79:64];
        n_in.moisture_a       = i_s_tdata[89:80];
        n_in.moisture_b       = i_s_tdata[99:90];
        n_in.moisture_c       = i_s_tdata[109:100];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in <= n_in;
        end
    end

    // slot engine: state updates at the edge where the item moves to the result register
    sslt_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (eng_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= eng_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out.slot_index, r_out.led_bits};
    assign o_m_tuser  = r_out.slot_found;

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !i_m_tready |-> !o_s_tready)
        else $error("input taken while both stages are blocked");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("processed item did not reach the result register");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_tready |=> r_out_vld)
        else $error("stalled result was dropped");

endmodule
